// ----- rtl/core/blockwise_minmax_bounds_defines.svh -----
// Assertion macros for the bounding-box block.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef BLOCKWISE_MINMAX_BOUNDS_DEFINES_SVH
`define BLOCKWISE_MINMAX_BOUNDS_DEFINES_SVH

// same-cycle implication
`define BMB_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMB_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmb_pkg.sv -----
// Shared constants, types and helpers of the bounding-box block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmb_pkg;

    localparam int DEF_MAX_DIMS    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int DIM_CNT_W = 7;   // dim_count register
    localparam int DIM_IDX_W = 6;   // dim_index field
    localparam int BOX_W     = 16;  // box_size, box_index, pose counter
    localparam int OUT_W     = 32;  // min_value / max_value fields

    localparam int APB_DW    = 32;
    localparam int CFG_AW    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE  = 1'd1;

    localparam logic [DIM_CNT_W-1:0] DIM_COUNT_RST = 7'd1;
    localparam logic [BOX_W-1:0]     BOX_SIZE_RST  = 16'd16;

    typedef struct packed {
        logic [DIM_CNT_W-1:0] dim_count;
        logic [BOX_W-1:0]     box_size;
    } cfg_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } store_ctl_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bmb_if.sv -----
// Stream interfaces: pose values in, box extents out.
// Depends on bmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bmb_in_if #(
    parameter int VALUE_WIDTH = bmb_pkg::DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          end_of_set;

    modport source (output valid, value, end_of_set, input ready);
    modport sink   (input valid, value, end_of_set, output ready);
endinterface

interface bmb_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [bmb_pkg::BOX_W-1:0]     box_index;
    logic        [bmb_pkg::DIM_IDX_W-1:0] dim_index;
    logic signed [bmb_pkg::OUT_W-1:0]     min_value;
    logic signed [bmb_pkg::OUT_W-1:0]     max_value;
    logic                                 last_of_box;
    logic                                 last_of_set;

    modport source (output valid, box_index, dim_index, min_value, max_value,
                    last_of_box, last_of_set, input ready);
    modport sink   (input valid, box_index, dim_index, min_value, max_value,
                    last_of_box, last_of_set, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bmb_cfg.sv -----
// APB register file: dim_count and box_size.
// Depends on bmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmb_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bmb_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [bmb_pkg::APB_DW-1:0]   pwdata,
    output logic      [bmb_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output bmb_pkg::cfg_t                     cfg
);
    import bmb_pkg::*;

    logic [DIM_CNT_W-1:0] dim_count_reg, dim_count_next;
    logic [BOX_W-1:0]     box_size_reg, box_size_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_fire;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_fire = psel && penable && pwrite && pready;

    always_comb
    begin
        dim_count_next = dim_count_reg;
        box_size_next  = box_size_reg;
        if (wr_fire)
        begin
            case (reg_idx)
                REG_DIM_COUNT: dim_count_next = pwdata[DIM_CNT_W-1:0];
                REG_BOX_SIZE:  box_size_next  = pwdata[BOX_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= DIM_COUNT_RST;
            box_size_reg  <= BOX_SIZE_RST;
        end
        else
        begin
            dim_count_reg <= dim_count_next;
            box_size_reg  <= box_size_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DIM_COUNT: prdata = APB_DW'(dim_count_reg);
            REG_BOX_SIZE:  prdata = APB_DW'(box_size_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.dim_count = dim_count_reg;
    assign cfg.box_size  = box_size_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bmb_store.sv -----
// Per-dimension min/max store: one synchronous RAM, registered read,
// valid bits so unwritten entries read as the sentinel extremes. Depends on bmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmb_store #(
    parameter int MAX_DIMS    = bmb_pkg::DEF_MAX_DIMS,
    parameter int VALUE_WIDTH = bmb_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire bmb_pkg::store_ctl_t                       ctl,
    input  wire logic [bmb_pkg::addr_w(MAX_DIMS)-1:0]      rd_addr,
    input  wire logic [bmb_pkg::addr_w(MAX_DIMS)-1:0]      wr_addr,
    input  wire logic [2*VALUE_WIDTH-1:0]                  wr_data,
    output logic signed [VALUE_WIDTH-1:0]                  rd_min,
    output logic signed [VALUE_WIDTH-1:0]                  rd_max
);
    import bmb_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // word layout: {min, max}
    logic [2*VALUE_WIDTH-1:0] entry_mem [MAX_DIMS];
    logic [2*VALUE_WIDTH-1:0] q_reg;
    logic                     q_valid_reg;
    logic [MAX_DIMS-1:0]      valid_reg, valid_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= entry_mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr)
        begin
            valid_next = '0;
        end
        if (ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                q_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_min = q_valid_reg ? q_reg[2*VALUE_WIDTH-1:VALUE_WIDTH] : MOST_POS;
    assign rd_max = q_valid_reg ? q_reg[VALUE_WIDTH-1:0]             : MOST_NEG;

endmodule

`default_nettype wire

// ----- rtl/core/bmb_seq.sv -----
// Sequencer: pose/box counters, read-modify-write of the store with forwarding,
// box emission and the output register. Depends on bmb_pkg, bmb_if, defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "blockwise_minmax_bounds_defines.svh"

module bmb_seq #(
    parameter int MAX_DIMS    = bmb_pkg::DEF_MAX_DIMS,
    parameter int VALUE_WIDTH = bmb_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    bmb_in_if.sink                                    pose_in,
    bmb_out_if.source                                 box_out,
    input  wire bmb_pkg::cfg_t                        cfg,
    output bmb_pkg::store_ctl_t                       ctl,
    output logic [bmb_pkg::addr_w(MAX_DIMS)-1:0]      rd_addr,
    output logic [bmb_pkg::addr_w(MAX_DIMS)-1:0]      wr_addr,
    output logic [2*VALUE_WIDTH-1:0]                  wr_data,
    input  wire logic signed [VALUE_WIDTH-1:0]        rd_min,
    input  wire logic signed [VALUE_WIDTH-1:0]        rd_max
);
    import bmb_pkg::*;

    localparam int DIM_AW = addr_w(MAX_DIMS);
    localparam logic [DIM_CNT_W-1:0] DIMS_CAP = DIM_CNT_W'(MAX_DIMS);

    localparam logic [1:0] S_RUN   = 2'd0;  // taking pose values
    localparam logic [1:0] S_FLUSH = 2'd1;  // closing item's write lands
    localparam logic [1:0] S_EMIT  = 2'd2;  // one store read per dimension
    localparam logic [1:0] S_DRAIN = 2'd3;  // last read waits for output slot

    logic [1:0]                     state_reg, state_next;
    logic [DIM_IDX_W-1:0]           dim_cnt_reg, dim_cnt_next;
    logic [BOX_W-1:0]               pose_cnt_reg, pose_cnt_next;
    logic [BOX_W-1:0]               box_cnt_reg, box_cnt_next;
    logic [BOX_W-1:0]               emit_box_reg, emit_box_next;
    logic                           emit_eos_reg, emit_eos_next;

    logic                           upd_v_reg, upd_v_next;
    logic [DIM_AW-1:0]              upd_addr_reg, upd_addr_next;
    logic signed [VALUE_WIDTH-1:0]  upd_val_reg, upd_val_next;
    logic                           fwd_reg, fwd_next;
    logic signed [VALUE_WIDTH-1:0]  fwd_min_reg, fwd_max_reg;

    logic [DIM_CNT_W-1:0]           emit_idx_reg, emit_idx_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic [DIM_IDX_W-1:0]           rd_pend_idx_reg, rd_pend_idx_next;
    logic                           rd_pend_last_reg, rd_pend_last_next;

    logic                           out_valid_reg, out_valid_next;
    logic [BOX_W-1:0]               box_index_reg;
    logic [DIM_IDX_W-1:0]           dim_index_reg;
    logic [OUT_W-1:0]               min_value_reg, max_value_reg;
    logic                           last_of_box_reg, last_of_set_reg;

    logic [DIM_CNT_W-1:0]           dims_eff;
    logic [BOX_W-1:0]               box_eff;
    logic                           in_acc, pose_end, box_end;
    logic [BOX_W-1:0]               pose_inc;
    logic signed [VALUE_WIDTH-1:0]  cur_min, cur_max, new_min, new_max;
    logic                           load, issue, emit_last, dim_in_range;
    logic [VALUE_WIDTH+OUT_W-1:0]   ext_min, ext_max;

    // effective sizes: zero means one, dims saturate at the store depth
    always_comb
    begin
        if (cfg.dim_count == '0)
            dims_eff = DIM_CNT_W'(1);
        else if (cfg.dim_count > DIMS_CAP)
            dims_eff = DIMS_CAP;
        else
            dims_eff = cfg.dim_count;
    end

    assign box_eff = (cfg.box_size == '0) ? BOX_W'(1) : cfg.box_size;

    assign pose_in.ready = (state_reg == S_RUN);
    assign in_acc        = pose_in.valid && pose_in.ready;

    assign pose_end = ((DIM_CNT_W'(dim_cnt_reg) + DIM_CNT_W'(1)) >= dims_eff)
                      || pose_in.end_of_set;
    assign pose_inc = pose_cnt_reg + BOX_W'(1);
    assign box_end  = pose_end && ((pose_inc >= box_eff) || pose_in.end_of_set);

    // modify stage; the store read is one write stale when the same entry repeats
    assign cur_min = fwd_reg ? fwd_min_reg : rd_min;
    assign cur_max = fwd_reg ? fwd_max_reg : rd_max;
    assign new_min = (upd_val_reg < cur_min) ? upd_val_reg : cur_min;
    assign new_max = (upd_val_reg > cur_max) ? upd_val_reg : cur_max;

    // emission
    assign load      = rd_pend_reg && (!out_valid_reg || box_out.ready);
    assign issue     = (state_reg == S_EMIT) && (!rd_pend_reg || load);
    assign emit_last = ((emit_idx_reg + DIM_CNT_W'(1)) == dims_eff);

    assign ctl.rd_en = in_acc || issue;
    assign ctl.wr_en = upd_v_reg;
    assign ctl.clr   = issue && emit_last;
    assign rd_addr   = (state_reg == S_EMIT) ? emit_idx_reg[DIM_AW-1:0]
                                             : dim_cnt_reg[DIM_AW-1:0];
    assign wr_addr   = upd_addr_reg;
    assign wr_data   = {new_min, new_max};

    assign ext_min = {{OUT_W{1'b0}}, rd_min};
    assign ext_max = {{OUT_W{1'b0}}, rd_max};

    always_comb
    begin
        state_next        = state_reg;
        dim_cnt_next      = dim_cnt_reg;
        pose_cnt_next     = pose_cnt_reg;
        box_cnt_next      = box_cnt_reg;
        emit_box_next     = emit_box_reg;
        emit_eos_next     = emit_eos_reg;
        upd_v_next        = in_acc;
        upd_addr_next     = upd_addr_reg;
        upd_val_next      = upd_val_reg;
        fwd_next          = in_acc && upd_v_reg
                            && (upd_addr_reg == dim_cnt_reg[DIM_AW-1:0]);
        emit_idx_next     = emit_idx_reg;
        rd_pend_next      = issue ? 1'b1 : (load ? 1'b0 : rd_pend_reg);
        rd_pend_idx_next  = rd_pend_idx_reg;
        rd_pend_last_next = rd_pend_last_reg;
        out_valid_next    = load ? 1'b1 : (box_out.ready ? 1'b0 : out_valid_reg);

        if (in_acc)
        begin
            upd_addr_next = dim_cnt_reg[DIM_AW-1:0];
            upd_val_next  = pose_in.value;
            dim_cnt_next  = pose_end ? '0 : dim_cnt_reg + DIM_IDX_W'(1);
            if (pose_end)
                pose_cnt_next = pose_inc;
            if (box_end)
            begin
                pose_cnt_next = '0;
                emit_box_next = box_cnt_reg;
                emit_eos_next = pose_in.end_of_set;
                box_cnt_next  = pose_in.end_of_set ? '0 : box_cnt_reg + BOX_W'(1);
            end
        end

        if (issue)
        begin
            emit_idx_next     = emit_idx_reg + DIM_CNT_W'(1);
            rd_pend_idx_next  = emit_idx_reg[DIM_IDX_W-1:0];
            rd_pend_last_next = emit_last;
        end

        case (state_reg)
            S_RUN:
            begin
                if (in_acc && box_end)
                begin
                    state_next    = S_FLUSH;
                    emit_idx_next = '0;
                end
            end
            S_FLUSH:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (issue && emit_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (load)
                    state_next = S_RUN;
            end
            default:
                state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            dim_cnt_reg   <= '0;
            pose_cnt_reg  <= '0;
            box_cnt_reg   <= '0;
            emit_box_reg  <= '0;
            emit_eos_reg  <= 1'b0;
            upd_v_reg     <= 1'b0;
            fwd_reg       <= 1'b0;
            emit_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_cnt_reg   <= dim_cnt_next;
            pose_cnt_reg  <= pose_cnt_next;
            box_cnt_reg   <= box_cnt_next;
            emit_box_reg  <= emit_box_next;
            emit_eos_reg  <= emit_eos_next;
            upd_v_reg     <= upd_v_next;
            fwd_reg       <= fwd_next;
            emit_idx_reg  <= emit_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_addr_reg     <= upd_addr_next;
        upd_val_reg      <= upd_val_next;
        fwd_min_reg      <= new_min;
        fwd_max_reg      <= new_max;
        rd_pend_idx_reg  <= rd_pend_idx_next;
        rd_pend_last_reg <= rd_pend_last_next;
        if (load)
        begin
            box_index_reg   <= emit_box_reg;
            dim_index_reg   <= rd_pend_idx_reg;
            min_value_reg   <= ext_min[OUT_W-1:0];
            max_value_reg   <= ext_max[OUT_W-1:0];
            last_of_box_reg <= rd_pend_last_reg;
            last_of_set_reg <= rd_pend_last_reg && emit_eos_reg;
        end
    end

    assign box_out.valid       = out_valid_reg;
    assign box_out.box_index   = box_index_reg;
    assign box_out.dim_index   = dim_index_reg;
    assign box_out.min_value   = min_value_reg;
    assign box_out.max_value   = max_value_reg;
    assign box_out.last_of_box = last_of_box_reg;
    assign box_out.last_of_set = last_of_set_reg;

    assign dim_in_range = (DIM_CNT_W'(dim_cnt_reg) < DIMS_CAP);

    `BMB_CHECK(a_upd_outside_emit, upd_v_reg, (state_reg == S_RUN) || (state_reg == S_FLUSH), "store update overlaps box emission")
    `BMB_CHECK_NEXT(a_flush_then_emit, state_reg == S_FLUSH, state_reg == S_EMIT, "flush not followed by emission")
    `BMB_CHECK(a_dim_cnt_in_store, 1'b1, dim_in_range, "dimension counter beyond store depth")
    `BMB_CHECK(a_pend_only_emitting, rd_pend_reg, (state_reg == S_EMIT) || (state_reg == S_DRAIN), "pending store read outside emission")

endmodule

`default_nettype wire

// ----- rtl/core/blockwise_minmax_bounds.sv -----
// Top level of the blockwise min/max (bounding box) block.
// Depends on bmb_pkg, bmb_if, bmb_cfg, bmb_store, bmb_seq.
//
//  channel   | dir | handshake         | contents
//  ----------+-----+-------------------+-----------------------------------------
//  pose_in   | in  | valid/ready       | value (signed), end_of_set
//  box_out   | out | valid/ready       | box_index, dim_index, min/max, last flags
//  apb       | in  | psel/penable      | dim_count @0x0, box_size @0x4
//
// One pose value per cycle while a box is filling: the store is read at accept
// and written back the next cycle, with forwarding when one entry repeats.
// After a closing item no further value is taken until its box has been read out:
// first its write lands, then one store read per dimension through the
// single read port, one result per cycle into the output register.
// Output stalls stretch the emission; values are still taken while the last
// result of a box waits in the output register.
// Reset is asynchronous and immediate: per-entry valid bits make the whole store
// read as the sentinel extremes, so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module blockwise_minmax_bounds #(
    parameter int MAX_DIMS    = bmb_pkg::DEF_MAX_DIMS,
    parameter int VALUE_WIDTH = bmb_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bmb_in_if.sink                           pose_in,
    bmb_out_if.source                        box_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bmb_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [bmb_pkg::APB_DW-1:0]  pwdata,
    output logic      [bmb_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import bmb_pkg::*;

    localparam int DIM_AW = addr_w(MAX_DIMS);

    cfg_t                          cfg;
    store_ctl_t                    ctl;
    logic [DIM_AW-1:0]             rd_addr, wr_addr;
    logic [2*VALUE_WIDTH-1:0]      wr_data;
    logic signed [VALUE_WIDTH-1:0] rd_min, rd_max;

    // register file
    bmb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // running extents, one {min, max} word per dimension
    bmb_store #(
        .MAX_DIMS    (MAX_DIMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_min  (rd_min),
        .rd_max  (rd_max)
    );

    // counters, read-modify-write, emission and output register
    bmb_seq #(
        .MAX_DIMS    (MAX_DIMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .pose_in (pose_in),
        .box_out (box_out),
        .cfg     (cfg),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_min  (rd_min),
        .rd_max  (rd_max)
    );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for blockwise_minmax_bounds: pose values in, per-box extents out.
// Needs bmb_pkg, bmb_if and the RTL of the block; each checked transfer is compared
// against a cycle-free model of the box bookkeeping kept in this file.
`timescale 1ns / 1ps

module tb;
    import bmb_pkg::*;

    // The close of a box reads the store once per dimension, so twice the widest pose is ample slack.
    localparam int SETTLE_CYCLES = 2 * DEF_MAX_DIMS + 8;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off in the pressure test
    localparam int RANDOM_ITEMS  = 150;
    localparam int IDLE_PCT      = 26;    // percent of cycles a side idles while gaps are on
    localparam int STREAM_ITEMS  = 48;    // gap-free stretch: 16 poses of 3 values

    localparam logic signed [OUT_W-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] MOST_NEG = 32'h8000_0000;

    typedef struct {
        logic        [BOX_W-1:0]     box_index;
        logic        [DIM_IDX_W-1:0] dim_index;
        logic signed [OUT_W-1:0]     min_value;
        logic signed [OUT_W-1:0]     max_value;
        logic                        last_of_box;
        logic                        last_of_set;
    } box_extent_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bmb_in_if  pose_ch ();
    bmb_out_if box_ch ();

    blockwise_minmax_bounds DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pose_in (pose_ch),
        .box_out (box_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Box model: its own copy of the registers, the per-dimension extents
    // and the three counters, advanced once per accepted pose value.
    // ------------------------------------------------------------------
    logic        [DIM_CNT_W-1:0] cfg_dims;
    logic        [BOX_W-1:0]     cfg_box;
    logic signed [OUT_W-1:0]     lo_ext [DEF_MAX_DIMS];
    logic signed [OUT_W-1:0]     hi_ext [DEF_MAX_DIMS];
    logic        [DIM_IDX_W-1:0] dim_pos;
    logic        [BOX_W-1:0]     pose_pos;
    logic        [BOX_W-1:0]     box_num;

    box_extent_t expected_extents [$];
    int          error_count = 0;

    // Both sides idle at random while this is set; cleared for the gap-free stretches.
    bit gaps_on = 1'b1;
    // Set by a test to start a long receiver hold-off; the receiver clears it.
    bit hold_start = 1'b0;
    int hold_left = 0;

    function automatic int active_dims();
        int d;
        d = cfg_dims;
        if (d == 0)
        begin
            d = 1;
        end
        if (d > DEF_MAX_DIMS)
        begin
            d = DEF_MAX_DIMS;
        end
        return d;
    endfunction

    function automatic int active_box();
        return (cfg_box == '0) ? 1 : int'(cfg_box);
    endfunction

    // Sentinels: an untouched dimension reports min = most positive, max = most negative.
    function automatic void clear_extents();
        for (int i = 0; i < DEF_MAX_DIMS; i++)
        begin
            lo_ext[i] = MOST_POS;
            hi_ext[i] = MOST_NEG;
        end
    endfunction

    function automatic void predict_bounds(input logic signed [OUT_W-1:0] v, input logic eos);
        int          d;
        int          dims;
        box_extent_t e;
        d    = dim_pos;
        dims = active_dims();
        if (v < lo_ext[d])
        begin
            lo_ext[d] = v;
        end
        if (v > hi_ext[d])
        begin
            hi_ext[d] = v;
        end
        dim_pos = dim_pos + 1'b1;
        // ">=" so that a pose or box already past a shrunken size closes at once
        if (d + 1 >= dims || eos)
        begin
            dim_pos  = '0;
            pose_pos = pose_pos + 1'b1;
            if (int'(pose_pos) >= active_box() || eos)
            begin
                for (int i = 0; i < dims; i++)
                begin
                    e.box_index   = box_num;
                    e.dim_index   = i[DIM_IDX_W-1:0];
                    e.min_value   = lo_ext[i];
                    e.max_value   = hi_ext[i];
                    e.last_of_box = (i + 1 == dims);
                    e.last_of_set = eos && (i + 1 == dims);
                    expected_extents.push_back(e);
                end
                clear_extents();
                pose_pos = '0;
                box_num  = eos ? '0 : box_num + 1'b1;  // wraps mod 2^16
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: check the transfer seen at this edge, then pick ready.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_extent();
        box_extent_t e;
        if (expected_extents.size() == 0)
        begin
            $error("unexpected transfer: box_index %0d dim_index %0d",
                   box_ch.box_index, box_ch.dim_index);
            error_count++;
        end
        else
        begin
            e = expected_extents.pop_front();
            compare_field("box_index",   e.box_index,   box_ch.box_index);
            compare_field("dim_index",   e.dim_index,   box_ch.dim_index);
            compare_field("min_value",   e.min_value,   box_ch.min_value);
            compare_field("max_value",   e.max_value,   box_ch.max_value);
            compare_field("last_of_box", e.last_of_box, box_ch.last_of_box);
            compare_field("last_of_set", e.last_of_set, box_ch.last_of_set);
        end
    endtask

    always @(posedge clk)
    begin
        // values read here are the ones present at the edge, before any update
        if (rst_n && box_ch.valid && box_ch.ready)
        begin
            check_extent();
        end
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            box_ch.ready <= 1'b0;
        end
        else
        begin
            box_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Setup cycle, then access cycle; the register takes the data on the
    // edge where the access phase meets pready.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DIM_COUNT: cfg_dims = data[DIM_CNT_W-1:0];
            REG_BOX_SIZE:  cfg_box  = data[BOX_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one pose value; valid stays high into the next call unless a gap is drawn.
    task automatic send_value(input logic signed [OUT_W-1:0] v, input logic eos);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            pose_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pose_ch.valid      <= 1'b1;
        pose_ch.value      <= v;
        pose_ch.end_of_set <= eos;
        do @(posedge clk); while (!pose_ch.ready);
        predict_bounds(v, eos);
    endtask

    // Stop offering, wait for every expected extent, then give the block time
    // to finish any item that closed nothing before the registers change.
    task automatic settle();
        pose_ch.valid <= 1'b0;
        while (expected_extents.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mix of extremes, near-zero ties and full-range values.
    function automatic logic signed [OUT_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return MOST_POS;
            1: return MOST_NEG;
            2: return $signed($urandom_range(4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: one value per pose, 16 poses per box; end of set closes box 0 early.
    task automatic test_reset_defaults();
        send_value(MOST_POS, 1'b0);
        send_value(MOST_NEG, 1'b0);
        send_value(32'sd0, 1'b0);
        send_value(-32'sd1, 1'b0);
        send_value(32'sd1, 1'b0);
        send_value(rand_value(), 1'b1);
        settle();
    endtask

    // End of set after two of four values: dimensions 2 and 3 report the sentinels.
    task automatic test_partial_pose();
        write_reg(REG_DIM_COUNT, 32'd4);
        write_reg(REG_BOX_SIZE, 32'd2);
        send_value(32'sh0001_8000, 1'b0);
        send_value(-32'sh0002_4000, 1'b1);
        settle();
    endtask

    // dim_count 0 acts as 1; the 7-bit maximum saturates to the full 64 dimensions.
    task automatic test_dim_count_limits();
        write_reg(REG_DIM_COUNT, 32'd0);
        send_value(rand_value(), 1'b1);
        settle();
        write_reg(REG_DIM_COUNT, 32'd127);
        send_value(rand_value(), 1'b1);
        settle();
    endtask

    // box_size 0 acts as 1; largest box, then shrink it and a pose shrink mid-flight.
    task automatic test_box_size_limits();
        write_reg(REG_DIM_COUNT, 32'd2);
        write_reg(REG_BOX_SIZE, 32'd0);
        send_value(rand_value(), 1'b0);
        send_value(rand_value(), 1'b0);
        settle();
        write_reg(REG_BOX_SIZE, 32'd65535);
        repeat (4) send_value(rand_value(), 1'b0);
        settle();
        // two poses already counted: the next full pose closes the box at once
        write_reg(REG_BOX_SIZE, 32'd1);
        send_value(rand_value(), 1'b0);
        send_value(rand_value(), 1'b0);
        settle();
        // two values into a three-value pose, then the pose shrinks to one
        write_reg(REG_DIM_COUNT, 32'd3);
        send_value(rand_value(), 1'b0);
        send_value(rand_value(), 1'b0);
        settle();
        write_reg(REG_DIM_COUNT, 32'd1);
        send_value(rand_value(), 1'b0);
        settle();
    endtask

    // Receiver holds off while poses keep coming, so the output backs up into
    // the input; afterwards the sender waits for the backlog to drain.
    task automatic test_backpressure();
        write_reg(REG_DIM_COUNT, 32'd4);
        write_reg(REG_BOX_SIZE, 32'd1);
        hold_start = 1'b1;
        repeat (24) send_value(rand_value(), 1'b0);
        pose_ch.valid <= 1'b0;
        while (expected_extents.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (7) send_value(rand_value(), 1'b0);
        send_value(rand_value(), 1'b1);
        settle();
    endtask

    // Random data sets: mostly whole poses closed by end of set, some cut mid-pose,
    // some left open across a register change, some with stray end-of-set flags.
    task automatic test_random_sets();
        int          sent;
        int          phase;
        int          dims;
        int          poses;
        int          n_items;
        int          style;
        logic        eos;
        logic [31:0] dim_word;
        logic [31:0] box_word;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0: dim_word = 64;
                1: dim_word = $urandom_range(65, 127);
                2: dim_word = 0;
                default: dim_word = $urandom_range(1, 6);
            endcase
            case ($urandom_range(9))
                0: box_word = 0;
                1: box_word = 65535;
                2: box_word = $urandom_range(9, 40);
                default: box_word = $urandom_range(1, 4);
            endcase
            // upper bits are outside the fields and must be ignored
            dim_word = ($urandom & ~32'h7F) | dim_word;
            box_word = ($urandom & ~32'hFFFF) | box_word;
            write_reg(REG_DIM_COUNT, dim_word);
            write_reg(REG_BOX_SIZE, box_word);
            gaps_on = (phase % 4 != 2);
            dims    = active_dims();
            if (dims > 8)
            begin
                poses = 1;
            end
            else
            begin
                poses = $urandom_range(1, (active_box() > 4) ? 6 : 3 * active_box());
            end
            n_items = poses * dims;
            style   = $urandom_range(9);
            if ((style == 6 || style == 7) && dims > 1)
            begin
                n_items -= $urandom_range(1, dims - 1);
            end
            for (int k = 0; k < n_items; k++)
            begin
                eos = (style <= 7 && k == n_items - 1) || (style == 9 && $urandom_range(9) == 0);
                send_value(rand_value(), eos);
            end
            sent += n_items;
            phase++;
            settle();
        end
        gaps_on = 1'b1;
    endtask

    // Long gap-free stretch on both sides: three-value poses, two poses per box.
    task automatic test_no_idle();
        write_reg(REG_DIM_COUNT, 32'd3);
        write_reg(REG_BOX_SIZE, 32'd2);
        gaps_on = 1'b0;
        repeat (STREAM_ITEMS - 1) send_value(rand_value(), 1'b0);
        send_value(rand_value(), 1'b1);
        settle();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pose_ch.valid      = 1'b0;
        pose_ch.value      = '0;
        pose_ch.end_of_set = 1'b0;
        box_ch.ready       = 1'b0;
        cfg_dims           = DIM_COUNT_RST;
        cfg_box            = BOX_SIZE_RST;
        dim_pos            = '0;
        pose_pos           = '0;
        box_num            = '0;
        clear_extents();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_partial_pose();
        test_dim_count_limits();
        test_box_size_limits();
        test_backpressure();
        test_random_sets();
        test_no_idle();
        settle();

        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bmb_pkg.sv
rtl/core/bmb_if.sv
rtl/core/bmb_cfg.sv
rtl/core/bmb_store.sv
rtl/core/bmb_seq.sv
rtl/core/blockwise_minmax_bounds.sv
sim/tb.sv
